/* rtl/scba_pkg.sv */
// Shared types and constants of the size-class block allocator.
`timescale 1ns / 1ps

package scba_pkg;

  localparam int unsigned HEAP_BYTES    = 1048576;
  localparam int unsigned NUM_CLASSES   = 13;
  localparam int unsigned MIN_BLOCK     = 16;
  localparam int unsigned GRANULE_BYTES = 16;

  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned LINK_W  = IDX_W + 1;
  localparam int unsigned ARENA_W = 17;
  localparam int unsigned CLS_W   = 4;

  // link store holds one entry per granule; heap size is a power of two
  localparam int unsigned LINK_DEPTH     = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned LINK_RAM_DEPTH = (LINK_DEPTH < 65536) ? LINK_DEPTH : 65536;
  localparam int unsigned LINK_AW        = $clog2(LINK_RAM_DEPTH);
  localparam logic [ARENA_W-1:0] ARENA_CAP = ARENA_W'(LINK_RAM_DEPTH);

  localparam int unsigned HEAD_AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef enum logic [2:0] {
    ST_REUSED  = 3'd0,
    ST_NEW     = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_IGNORED = 3'd3,
    ST_FREED   = 3'd4
  } status_e;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address_out;
    status_e           status;
  } rsp_t;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic               hit;
    logic [ARENA_W-1:0] gran;
  } dec_t;

endpackage

/* rtl/scba_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module scba_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/scba_decode.sv */
// Request size decode: size class, class range check and block size in granules.
`timescale 1ns / 1ps

module scba_decode (
  input  scba_pkg::req_t req_i,
  output scba_pkg::dec_t dec_o
);
  import scba_pkg::*;

  logic [SIZE_W-1:0] size_m1;
  logic [CLS_W-1:0]  msb;
  logic [CLS_W-1:0]  cls;

  always_comb begin
    size_m1 = req_i.size - SIZE_W'(1);
    msb     = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) begin
        msb = CLS_W'(i);
      end
    end
    // blocks above the minimum: class = ceil(log2(size)) - 4
    if (req_i.size <= SIZE_W'(MIN_BLOCK)) begin
      cls = '0;
    end else begin
      cls = msb - CLS_W'(3);
    end
    dec_o.cls  = cls;
    dec_o.hit  = (req_i.size != '0) && ({1'b0, cls} < (CLS_W + 1)'(NUM_CLASSES));
    dec_o.gran = ARENA_W'(1) << cls;
  end

endmodule

/* rtl/size_class_block_allocator.sv */
// Top level of the size-class block allocator: sequencer, head and link memories.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low, and its word comes back on rsp_o
// with done_o high for exactly one cycle; the receiver cannot stall it. A free, a zero-size
// or out-of-range request, and an allocation served from the arena are settled in the head
// state, and busy drops in the same cycle that done_o rises; no request is taken before. An
// allocation that pops a free list goes on to the link state: one read of the class head
// memory, then one read of the link memory for the next head. The arena register may be
// written through the cfg channel, which is always ready; write it only while idle.
module size_class_block_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  scba_pkg::req_t                  req_i,
  output logic                            done_o,
  output scba_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scba_pkg::ARENA_W-1:0]    cfg_data_i
);
  import scba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_LINK
  } state_e;

  state_e               state_q, state_d;
  req_t                 req_q, req_d;
  dec_t                 dec_q, dec_d;
  logic [NUM_CLASSES-1:0] head_vld_q, head_vld_d;
  logic [ARENA_W-1:0]   bump_q, bump_d;
  logic [ARENA_W-1:0]   arena_q, arena_d;
  logic [IDX_W-1:0]     pop_idx_q, pop_idx_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  dec_t                 dec_in;
  logic                 accept;

  logic                 head_we;
  logic [HEAD_AW-1:0]   head_addr;
  logic [LINK_W-1:0]    head_wdata;
  logic [LINK_W-1:0]    head_rdata;
  logic [LINK_W-1:0]    head_word;

  logic                 link_we;
  logic                 link_re;
  logic [LINK_AW-1:0]   link_waddr;
  logic [LINK_AW-1:0]   link_raddr;
  logic [LINK_W-1:0]    link_rdata;

  logic [IDX_W-1:0]     free_idx;
  logic [ARENA_W-1:0]   limit;
  logic [ARENA_W:0]     bump_sum;

  scba_decode u_decode (
    .req_i (req_i),
    .dec_o (dec_in)
  );

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign head_addr   = dec_q.cls[HEAD_AW-1:0];

  scba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_CLASSES)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_addr),
    .wdata_i (head_wdata),
    .re_i    (accept),
    .raddr_i (dec_in.cls[HEAD_AW-1:0]),
    .rdata_o (head_rdata)
  );

  scba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_RAM_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (head_word),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // an empty class reads as zero regardless of memory contents
  assign head_word  = head_vld_q[head_addr] ? head_rdata : '0;
  assign free_idx   = req_q.address[ADDR_W-1 -: IDX_W];
  assign link_waddr = free_idx[LINK_AW-1:0];
  assign link_raddr = head_word[LINK_AW-1:0];
  assign limit      = (arena_q < ARENA_CAP) ? arena_q : ARENA_CAP;
  assign bump_sum   = {1'b0, bump_q} + {1'b0, dec_q.gran};

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    dec_d      = dec_q;
    head_vld_d = head_vld_q;
    bump_d     = bump_q;
    arena_d    = arena_q;
    pop_idx_d  = pop_idx_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    head_we    = 1'b0;
    head_wdata = head_word;
    link_we    = 1'b0;
    link_re    = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      arena_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_i;
          dec_d   = dec_in;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        rsp_d.address_out = '0;
        if (!dec_q.hit) begin
          rsp_d.status = ST_IGNORED;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (req_q.func == FN_FREE) begin
          link_we               = 1'b1;
          head_we               = 1'b1;
          head_wdata            = {1'b1, free_idx};
          head_vld_d[head_addr] = 1'b1;
          rsp_d.status          = ST_FREED;
          done_d                = 1'b1;
          state_d               = S_IDLE;
        end else if (head_word[IDX_W]) begin
          link_re   = 1'b1;
          pop_idx_d = head_word[IDX_W-1:0];
          state_d   = S_LINK;
        end else begin
          if (bump_sum <= {1'b0, limit}) begin
            rsp_d.address_out = {bump_q[IDX_W-1:0], 4'b0000};
            rsp_d.status      = ST_NEW;
            bump_d            = bump_sum[ARENA_W-1:0];
          end else begin
            rsp_d.status = ST_NOSPACE;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LINK: begin
        head_we               = 1'b1;
        head_wdata            = link_rdata;
        head_vld_d[head_addr] = link_rdata[IDX_W];
        rsp_d.address_out     = {pop_idx_q, 4'b0000};
        rsp_d.status          = ST_REUSED;
        done_d                = 1'b1;
        state_d               = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_vld_q <= '0;
      bump_q     <= '0;
      arena_q    <= ARENA_W'(65536);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_vld_q <= head_vld_d;
      bump_q     <= bump_d;
      arena_q    <= arena_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    dec_q     <= dec_d;
    pop_idx_q <= pop_idx_d;
    rsp_q     <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_accept_to_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_HEAD))
    else $error("accepted request did not start a head read");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) != S_IDLE))
    else $error("result word without a request in flight");

  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= ARENA_CAP)
    else $error("bump pointer beyond heap");

  a_pop_reads_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> $past(link_re))
    else $error("list pop without a link read");

endmodule

/* test/tb.sv */
// Testbench for the size-class block allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb;
  import scba_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  req_t               req_i;
  logic               done_o;
  rsp_t               rsp_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ARENA_W-1:0] cfg_data_i;

  // allocator state as predicted
  logic [LINK_W-1:0]  class_head [NUM_CLASSES];
  logic [LINK_W-1:0]  next_link [LINK_RAM_DEPTH];
  logic [ARENA_W-1:0] bump_gran;
  logic [ARENA_W-1:0] arena_gran;

  rsp_t        pending_rsps [$];
  live_block_t live_blocks [$];
  int          fault_count;

  size_class_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // smallest k with 2^k >= max(16, size)
  function automatic int unsigned block_order(logic [SIZE_W-1:0] sz);
    int unsigned need;
    int unsigned k;
    need = (sz < MIN_BLOCK) ? MIN_BLOCK : sz;
    k = 4;
    while (k < 16 && (32'd1 << k) < need) k++;
    return k;
  endfunction

  function automatic logic [SIZE_W-1:0] size_in_order(int unsigned k);
    int unsigned lo;
    int unsigned hi;
    lo = (k == 4) ? 1 : (32'd1 << (k - 1)) + 1;
    hi = (k == 16) ? 65535 : (32'd1 << k);
    return SIZE_W'($urandom_range(hi, lo));
  endfunction

  function automatic rsp_t predict_alloc_rsp(req_t r);
    int unsigned      k;
    int unsigned      cls;
    int unsigned      gran;
    int unsigned      lim;
    logic [IDX_W-1:0] g;
    rsp_t             rsp;
    rsp.address_out = '0;
    rsp.status      = ST_IGNORED;
    if (r.size != 0) begin
      k   = block_order(r.size);
      cls = k - 4;
      if (cls < NUM_CLASSES) begin
        if (r.func == FN_ALLOC) begin
          if (class_head[cls][IDX_W]) begin
            g               = class_head[cls][IDX_W-1:0];
            class_head[cls] = next_link[g];
            rsp.address_out = {g, 4'h0};
            rsp.status      = ST_REUSED;
          end else begin
            gran = (32'd1 << k) / GRANULE_BYTES;
            lim  = (arena_gran < LINK_RAM_DEPTH) ? arena_gran : LINK_RAM_DEPTH;
            if (bump_gran <= lim && gran <= lim - bump_gran) begin
              rsp.address_out = ADDR_W'(bump_gran * GRANULE_BYTES);
              bump_gran       = ARENA_W'(bump_gran + gran);
              rsp.status      = ST_NEW;
            end else begin
              rsp.status = ST_NOSPACE;
            end
          end
        end else begin
          g               = r.address[ADDR_W-1:4];
          next_link[g]    = class_head[cls];
          class_head[cls] = {1'b1, g};
          rsp.status      = ST_FREED;
        end
      end
    end
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check_rsp
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        $error("result word with none expected: address_out %h status %0d",
               rsp_o.address_out, rsp_o.status);
        fault_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_o.address_out !== want.address_out) begin
          $error("address_out: expected %h, got %h", want.address_out, rsp_o.address_out);
          fault_count++;
        end
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          fault_count++;
        end
      end
    end
  end

  // start stays high after acceptance; the next send or an idle step decides
  task automatic send_req(input func_e fn, input logic [SIZE_W-1:0] sz,
                          input logic [ADDR_W-1:0] ad, output rsp_t want);
    req_t r;
    r.func    = fn;
    r.size    = sz;
    r.address = ad;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    want = predict_alloc_rsp(r);
    pending_rsps.push_back(want);
    if (want.status == ST_REUSED || want.status == ST_NEW)
      live_blocks.push_back('{addr: want.address_out, size: sz});
  endtask

  task automatic hold_off(input int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_rsps();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_arena(input logic [ARENA_W-1:0] val);
    drain_rsps();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    arena_gran = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed_ops();
    rsp_t a;
    rsp_t b;
    rsp_t c;
    send_req(FN_ALLOC, 16'd0, 20'h00000, a);
    send_req(FN_FREE, 16'd0, 20'hFFFFF, a);
    send_req(FN_ALLOC, 16'd1, 20'h00000, a);
    send_req(FN_ALLOC, 16'd16, 20'hFFFFF, b);
    send_req(FN_ALLOC, 16'd17, 20'h00000, c);
    send_req(FN_ALLOC, 16'd65535, 20'h00000, c);
    send_req(FN_ALLOC, 16'd32769, 20'h00000, b);
    send_req(FN_FREE, 16'd65535, c.address_out, c);
    send_req(FN_FREE, 16'd16, a.address_out | 20'hF, a);
    // low address bits are dropped on free
    send_req(FN_FREE, 16'd1, 20'hFFFFF, a);
    send_req(FN_ALLOC, 16'd16, 20'h00000, a);
    send_req(FN_ALLOC, 16'd8, 20'h00000, a);
    send_req(FN_ALLOC, 16'd16, 20'h00000, a);
    send_req(FN_ALLOC, 16'd40000, 20'h00000, a);
    // free of a block never handed out
    send_req(FN_FREE, 16'd65535, 20'h00000, a);
  endtask

  task automatic test_arena_limits();
    rsp_t a;
    write_arena('0);
    send_req(FN_ALLOC, 16'd16, 20'h00000, a);
    send_req(FN_ALLOC, 16'd65535, 20'h00000, a);
    send_req(FN_ALLOC, 16'd65535, 20'h00000, a);
    write_arena(ARENA_W'(bump_gran + 1));
    send_req(FN_ALLOC, 16'd32, 20'h00000, a);
    send_req(FN_ALLOC, 16'd16, 20'h00000, a);
    send_req(FN_ALLOC, 16'd16, 20'h00000, a);
    write_arena({ARENA_W{1'b1}});
    send_req(FN_ALLOC, 16'd16, 20'h00000, a);
  endtask

  task automatic send_random_req(output rsp_t want);
    int unsigned       pick;
    int unsigned       idx;
    func_e             fn;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ad;
    live_block_t       blk;
    pick = $urandom_range(99, 0);
    fn   = FN_ALLOC;
    ad   = ADDR_W'($urandom_range(20'hFFFFF, 0));
    if (pick >= 46 && pick < 84 && live_blocks.size() == 0) pick = 0;
    if (pick < 46) begin
      sz = size_in_order($urandom_range(9, 4));
    end else if (pick < 84) begin
      idx = $urandom_range(live_blocks.size() - 1, 0);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      fn = FN_FREE;
      ad = blk.addr | ADDR_W'($urandom_range(15, 0));
      sz = ($urandom_range(2, 0) == 0) ? size_in_order(block_order(blk.size)) : blk.size;
    end else if (pick < 86) begin
      sz = SIZE_W'($urandom_range(65535, 1));
    end else if (pick < 94) begin
      fn = FN_FREE;
      sz = SIZE_W'($urandom_range(65535, 1));
    end else if (pick < 98) begin
      fn = FN_FREE;
      sz = SIZE_W'($urandom_range(256, 1));
    end else begin
      fn = ($urandom_range(1, 0) == 0) ? FN_ALLOC : FN_FREE;
      sz = '0;
    end
    send_req(fn, sz, ad, want);
  endtask

  task automatic test_random_traffic(input logic [ARENA_W-1:0] arena, input int unsigned n);
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    rsp_t        want;
    write_arena(arena);
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(20, 1);
      repeat (burst) begin
        send_random_req(want);
        if (want.status != ST_IGNORED) sent++;
      end
      pick = $urandom_range(19, 0);
      if (pick == 0) drain_rsps();
      else if (pick > 3) hold_off($urandom_range(9, 1));
    end
  endtask

  // run the arena dry at the capped limit, largest blocks first; a list that
  // loops back on itself after repeated frees never runs dry, so tries are capped
  task automatic test_arena_exhaustion();
    rsp_t        want;
    int unsigned tries;
    write_arena({ARENA_W{1'b1}});
    for (int k = 16; k >= 4; k--) begin
      tries = 0;
      do begin
        send_req(FN_ALLOC, (k == 16) ? 16'hFFFF : SIZE_W'(32'd1 << k), 20'h00000, want);
        tries++;
      end while (want.status != ST_NOSPACE && tries < 128);
    end
  endtask

  initial begin
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    fault_count = 0;
    bump_gran   = '0;
    arena_gran  = ARENA_W'(65536);
    for (int i = 0; i < NUM_CLASSES; i++) class_head[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_arena_limits();
    test_random_traffic(ARENA_W'(65536), 400);
    test_random_traffic(bump_gran + ARENA_W'($urandom_range(300, 16)), 300);
    test_random_traffic('0, 150);
    test_random_traffic(ARENA_W'($urandom_range(131071, 0)), 200);
    test_random_traffic({ARENA_W{1'b1}}, 300);
    test_arena_exhaustion();

    drain_rsps();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && pending_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
